>>> hw/rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, constants and helper functions of the LED pulse sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int PENDING_DEPTH_DEF = 4;
    localparam int FRAME_MIN_MS_DEF  = 12;

    localparam logic [2:0] REG_SEARCH_COLOR  = 3'd0;
    localparam logic [2:0] REG_LINKED_COLOR  = 3'd1;
    localparam logic [2:0] REG_SEARCH_PERIOD = 3'd2;
    localparam logic [2:0] REG_LINKED_PERIOD = 3'd3;
    localparam logic [2:0] REG_BG_FLOOR      = 3'd4;
    localparam logic [2:0] REG_SEARCH_PEAK   = 3'd5;
    localparam logic [2:0] REG_LINKED_PEAK   = 3'd6;

    localparam logic       KIND_START = 1'b0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_LINKED = 2'd2;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_CYCLE,
        DIV_PHASE,
        DIV_TRI
    } div_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_RENDER,
        ST_DIV_SEQ,
        ST_TRI_START,
        ST_DIV_TRI,
        ST_GAMMA,
        ST_BR,
        ST_SCALE,
        ST_EMIT,
        ST_FALLBACK,
        ST_BG_START,
        ST_DIV_BGP
    } state_t;

    typedef struct packed {
        logic    take_start;
        logic    take_tick;
        logic    tick_entry;
        logic    dequeue;
        logic    stop_seq;
        logic    set_dark;
        logic    set_off;
        logic    seq_params;
        logic    bg_params;
        logic    br_from_hi;
        div_op_t div_op;
        logic    gamma_mul;
        logic    br_calc;
        logic    scale_mul;
        logic    emit_load;
    } lps_cmd_t;

    typedef struct packed {
        logic       running;
        logic       pend_nonempty;
        logic       throttled;
        logic       elapsed_neg;
        logic       cycle_zero;
        logic       div_done;
        logic       past_end;
        logic       in_gap;
        logic       period_zero;
        logic       out_busy;
        logic [1:0] mode;
    } lps_status_t;

    localparam logic [7:0] GAMMA_LUT [256] = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
        8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,
        8'd5,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,
        8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,8'd12,8'd13,
        8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,8'd16,8'd16,
        8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,
        8'd21,8'd21,8'd22,8'd22,8'd23,8'd24,8'd24,8'd25,
        8'd25,8'd26,8'd27,8'd27,8'd28,8'd29,8'd29,8'd30,
        8'd31,8'd32,8'd32,8'd33,8'd34,8'd35,8'd35,8'd36,
        8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,
        8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,8'd50,8'd50,
        8'd51,8'd52,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,
        8'd60,8'd61,8'd62,8'd63,8'd64,8'd66,8'd67,8'd68,
        8'd69,8'd70,8'd72,8'd73,8'd74,8'd75,8'd77,8'd78,
        8'd79,8'd81,8'd82,8'd83,8'd85,8'd86,8'd87,8'd89,
        8'd90,8'd92,8'd93,8'd95,8'd96,8'd98,8'd99,8'd101,
        8'd102,8'd104,8'd105,8'd107,8'd109,8'd110,8'd112,8'd114,
        8'd115,8'd117,8'd119,8'd120,8'd122,8'd124,8'd126,8'd127,
        8'd129,8'd131,8'd133,8'd135,8'd137,8'd138,8'd140,8'd142,
        8'd144,8'd146,8'd148,8'd150,8'd152,8'd154,8'd156,8'd158,
        8'd160,8'd162,8'd164,8'd167,8'd169,8'd171,8'd173,8'd175,
        8'd177,8'd180,8'd182,8'd184,8'd186,8'd189,8'd191,8'd193,
        8'd196,8'd198,8'd200,8'd203,8'd205,8'd208,8'd210,8'd213,
        8'd215,8'd218,8'd220,8'd223,8'd225,8'd228,8'd231,8'd233,
        8'd236,8'd239,8'd241,8'd244,8'd247,8'd249,8'd252,8'd255
    };

    // pct * 255 / 100, saturated; reciprocal estimate plus one correction
    function automatic logic [7:0] pct_level(input logic [6:0] pct);
        logic [14:0] v;
        logic [24:0] est;
        logic [8:0]  q;
        logic [14:0] r;
        v   = 15'(pct) * 15'd255;
        est = {10'b0, v} * 25'd655;
        q   = est[24:16];
        r   = v - 15'(q) * 15'd100;
        if (r >= 15'd100)
        begin
            q = q + 9'd1;
        end
        return (q > 9'd255) ? 8'd255 : q[7:0];
    endfunction

    // x / 255 for 16-bit x
    function automatic logic [8:0] div255(input logic [15:0] x);
        logic [24:0] est;
        logic [8:0]  q;
        logic [16:0] r;
        est = {9'b0, x} * 25'd257;
        q   = est[24:16];
        r   = {1'b0, x} - 17'(q) * 17'd255;
        if (r >= 17'd255)
        begin
            q = q + 9'd1;
        end
        return q;
    endfunction

endpackage

>>> hw/rtl/lps_divider.sv
// ----------------------------------------------------------------------------
// lps_divider
// Radix-2 restoring divider, 32-bit dividend by 17-bit divisor.
// ----------------------------------------------------------------------------
module lps_divider import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic [31:0] quotient,
    output logic [16:0] remainder,
    output logic        busy,
    output logic        done
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] div_reg, div_next;
    logic [17:0] rem_shift;
    logic        ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[31]};
        ge        = rem_shift >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 17'(rem_shift - {1'b0, div_reg}) : rem_shift[16:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;
    assign done      = done_reg;

endmodule

>>> hw/rtl/lps_datapath.sv
// ----------------------------------------------------------------------------
// lps_datapath
// Config registers, pending queue, sequence state, divider and output stage.
// ----------------------------------------------------------------------------
module lps_datapath import lps_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int FRAME_MIN_MS  = FRAME_MIN_MS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lps_cmd_t    cmd,
    output lps_status_t status,
    input  logic [31:0] now_ms,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  pulse_count,
    input  logic [15:0] pulse_ms,
    input  logic [15:0] gap_ms,
    input  logic [6:0]  min_pct,
    input  logic [6:0]  max_pct,
    input  logic [15:0] delay_ms,
    input  logic [1:0]  background_mode,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        result_stall,
    output logic        result_valid,
    output logic [7:0]  led_red,
    output logic [7:0]  led_green,
    output logic [7:0]  led_blue,
    output logic        from_sequence
);

    localparam int PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    // config
    logic [23:0] search_color_reg, linked_color_reg;
    logic [15:0] search_period_reg, linked_period_reg;
    logic [6:0]  bg_floor_reg, search_peak_reg, linked_peak_reg;

    // sequence
    logic        running_reg, first_seen_reg;
    logic [23:0] seq_color_reg;
    logic [31:0] seq_start_reg, last_frame_reg;
    logic [15:0] seq_pulse_reg, seq_gap_reg;
    logic [7:0]  seq_pulses_reg;
    logic [6:0]  seq_floor_reg, seq_peak_reg;

    // pending queue
    logic [23:0] q_color_reg [PENDING_DEPTH];
    logic [31:0] q_start_reg [PENDING_DEPTH];
    logic [7:0]  q_pulses_reg [PENDING_DEPTH];
    logic [15:0] q_pulse_reg [PENDING_DEPTH];
    logic [15:0] q_gap_reg [PENDING_DEPTH];
    logic [6:0]  q_floor_reg [PENDING_DEPTH];
    logic [6:0]  q_peak_reg [PENDING_DEPTH];
    logic [PTR_W-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0] count_reg;

    // working registers
    logic [31:0] now_reg;
    logic [1:0]  mode_reg;
    logic [23:0] color_reg;
    logic [7:0]  lo_reg, hi_reg, br_reg;
    logic [15:0] period_reg;
    logic        from_reg;
    logic [15:0] prod_reg, prod_r_reg, prod_g_reg, prod_b_reg;

    logic        out_valid_reg;
    logic [7:0]  out_r_reg, out_g_reg, out_b_reg;
    logic        out_from_reg;

    logic [31:0] start_sum, elapsed, frame_gap, deq_start;
    logic [16:0] cycle_len;
    logic        item_nonempty, full, push_en, dequeue_en, direct_load;
    logic        throttled;

    logic        div_start, div_busy, div_done;
    logic [31:0] div_dividend, div_quo;
    logic [16:0] div_divisor, div_rem;
    logic [24:0] tri_prod;
    logic [8:0]  tri_raw, tri_fold;
    logic [7:0]  span, gamma_val;
    logic [8:0]  br_sum;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign start_sum     = now_ms + {16'b0, delay_ms};
    assign item_nonempty = (pulse_count != 8'd0) && (pulse_ms != 16'd0);
    assign full          = count_reg == CNT_W'(PENDING_DEPTH);
    assign direct_load   = cmd.take_start && first_seen_reg;
    assign push_en       = cmd.take_start && !first_seen_reg && item_nonempty;
    assign frame_gap     = now_reg - last_frame_reg;
    assign throttled     = (last_frame_reg != 32'd0) && (frame_gap < 32'(FRAME_MIN_MS));
    assign dequeue_en    = cmd.dequeue ||
                           (cmd.tick_entry && !first_seen_reg && !running_reg &&
                            (count_reg != '0));
    assign deq_start     = (q_start_reg[head_reg] > now_reg) ? q_start_reg[head_reg] : now_reg;
    assign elapsed       = now_reg - seq_start_reg;
    assign cycle_len     = {1'b0, seq_pulse_reg} + {1'b0, seq_gap_reg};

    // divider operand select
    assign tri_prod = {9'b0, div_rem[15:0]} * 25'd510;
    always_comb
    begin
        case (cmd.div_op)
            DIV_CYCLE:
            begin
                div_dividend = elapsed;
                div_divisor  = cycle_len;
            end
            DIV_PHASE:
            begin
                div_dividend = now_reg;
                div_divisor  = {1'b0, period_reg};
            end
            DIV_TRI:
            begin
                div_dividend = {7'b0, tri_prod};
                div_divisor  = {1'b0, period_reg};
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end
    assign div_start = cmd.div_op != DIV_NONE;

    lps_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .busy      (div_busy),
        .done      (div_done)
    );

    // triangle fold, gamma, span
    assign tri_raw   = div_quo[8:0];
    assign tri_fold  = (tri_raw > 9'd255) ? 9'd510 - tri_raw : tri_raw;
    assign gamma_val = GAMMA_LUT[tri_fold[7:0]];
    assign span      = (hi_reg > lo_reg) ? hi_reg - lo_reg : 8'd0;
    assign br_sum    = {1'b0, lo_reg} + div255(prod_reg);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_color_reg  <= 24'd255;
            linked_color_reg  <= 24'd255;
            search_period_reg <= 16'd1600;
            linked_period_reg <= 16'd500;
            bg_floor_reg      <= 7'd1;
            search_peak_reg   <= 7'd65;
            linked_peak_reg   <= 7'd80;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SEARCH_COLOR:  search_color_reg  <= cfg_data;
                REG_LINKED_COLOR:  linked_color_reg  <= cfg_data;
                REG_SEARCH_PERIOD: search_period_reg <= cfg_data[15:0];
                REG_LINKED_PERIOD: linked_period_reg <= cfg_data[15:0];
                REG_BG_FLOOR:      bg_floor_reg      <= cfg_data[6:0];
                REG_SEARCH_PEAK:   search_peak_reg   <= cfg_data[6:0];
                REG_LINKED_PEAK:   linked_peak_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sequence state and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            first_seen_reg <= 1'b0;
            seq_color_reg  <= '0;
            seq_start_reg  <= '0;
            seq_pulse_reg  <= '0;
            seq_gap_reg    <= '0;
            seq_pulses_reg <= '0;
            seq_floor_reg  <= '0;
            seq_peak_reg   <= '0;
            last_frame_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (direct_load)
            begin
                running_reg    <= item_nonempty;
                seq_color_reg  <= {red, green, blue};
                seq_start_reg  <= start_sum;
                seq_pulse_reg  <= pulse_ms;
                seq_gap_reg    <= gap_ms;
                seq_pulses_reg <= pulse_count;
                seq_floor_reg  <= min_pct;
                seq_peak_reg   <= max_pct;
            end
            else if (dequeue_en)
            begin
                running_reg    <= (q_pulses_reg[head_reg] != 8'd0) &&
                                  (q_pulse_reg[head_reg] != 16'd0);
                seq_color_reg  <= q_color_reg[head_reg];
                seq_start_reg  <= deq_start;
                seq_pulse_reg  <= q_pulse_reg[head_reg];
                seq_gap_reg    <= q_gap_reg[head_reg];
                seq_pulses_reg <= q_pulses_reg[head_reg];
                seq_floor_reg  <= q_floor_reg[head_reg];
                seq_peak_reg   <= q_peak_reg[head_reg];
            end
            else if (cmd.stop_seq)
            begin
                running_reg <= 1'b0;
            end

            if (cmd.tick_entry)
            begin
                first_seen_reg <= 1'b1;
                if (!throttled)
                begin
                    last_frame_reg <= now_reg;
                end
            end

            if (push_en)
            begin
                tail_reg <= ptr_inc(tail_reg);
                if (full)
                begin
                    head_reg <= ptr_inc(head_reg);
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (dequeue_en)
            begin
                head_reg  <= ptr_inc(head_reg);
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            q_color_reg[tail_reg]  <= {red, green, blue};
            q_start_reg[tail_reg]  <= start_sum;
            q_pulses_reg[tail_reg] <= pulse_count;
            q_pulse_reg[tail_reg]  <= pulse_ms;
            q_gap_reg[tail_reg]    <= gap_ms;
            q_floor_reg[tail_reg]  <= min_pct;
            q_peak_reg[tail_reg]   <= max_pct;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (cmd.take_tick)
        begin
            now_reg  <= now_ms;
            mode_reg <= background_mode;
        end
        if (cmd.seq_params)
        begin
            color_reg  <= seq_color_reg;
            lo_reg     <= pct_level(seq_floor_reg);
            hi_reg     <= pct_level(seq_peak_reg);
            period_reg <= seq_pulse_reg;
            from_reg   <= 1'b1;
        end
        else if (cmd.bg_params)
        begin
            lo_reg   <= pct_level(bg_floor_reg);
            from_reg <= 1'b0;
            if (mode_reg == MODE_SEARCH)
            begin
                color_reg  <= search_color_reg;
                hi_reg     <= pct_level(search_peak_reg);
                period_reg <= search_period_reg;
            end
            else
            begin
                color_reg  <= linked_color_reg;
                hi_reg     <= pct_level(linked_peak_reg);
                period_reg <= linked_period_reg;
            end
        end
        else if (cmd.set_dark || cmd.set_off)
        begin
            color_reg <= '0;
            from_reg  <= cmd.set_dark;
        end

        if (cmd.set_dark || cmd.set_off)
        begin
            br_reg <= '0;
        end
        else if (cmd.br_from_hi)
        begin
            br_reg <= hi_reg;
        end
        else if (cmd.br_calc)
        begin
            br_reg <= br_sum[7:0];
        end

        if (cmd.gamma_mul)
        begin
            prod_reg <= {8'b0, gamma_val} * {8'b0, span};
        end
        if (cmd.scale_mul)
        begin
            prod_r_reg <= {8'b0, color_reg[23:16]} * {8'b0, br_reg} + 16'd127;
            prod_g_reg <= {8'b0, color_reg[15:8]} * {8'b0, br_reg} + 16'd127;
            prod_b_reg <= {8'b0, color_reg[7:0]} * {8'b0, br_reg} + 16'd127;
        end
        if (cmd.emit_load)
        begin
            out_r_reg    <= 8'(div255(prod_r_reg));
            out_g_reg    <= 8'(div255(prod_g_reg));
            out_b_reg    <= 8'(div255(prod_b_reg));
            out_from_reg <= from_reg;
        end
    end

    always_comb
    begin
        status.running       = running_reg;
        status.pend_nonempty = count_reg != '0;
        status.throttled     = throttled;
        status.elapsed_neg   = elapsed[31];
        status.cycle_zero    = cycle_len == 17'd0;
        status.div_done      = div_done;
        status.past_end      = div_quo >= {24'b0, seq_pulses_reg};
        status.in_gap        = div_rem >= {1'b0, seq_pulse_reg};
        status.period_zero   = period_reg == 16'd0;
        status.out_busy      = out_valid_reg && result_stall;
        status.mode          = mode_reg;
    end

    assign result_valid  = out_valid_reg;
    assign led_red       = out_r_reg;
    assign led_green     = out_g_reg;
    assign led_blue      = out_b_reg;
    assign from_sequence = out_from_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> !(out_valid_reg && result_stall))
        else $error("result overwritten while stalled");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PENDING_DEPTH))
        else $error("pending count above depth");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_first_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        first_seen_reg |=> first_seen_reg)
        else $error("first tick flag cleared");

endmodule

>>> hw/rtl/lps_controller.sv
// ----------------------------------------------------------------------------
// lps_controller
// Sequencing of start requests and frame ticks through the datapath.
// ----------------------------------------------------------------------------
module lps_controller import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        kind,
    output logic        item_stall,
    input  lps_status_t status,
    output lps_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   retried_reg, retried_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            retried_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            retried_reg <= retried_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        retried_next = retried_reg;
        cmd          = '0;
        cmd.div_op   = DIV_NONE;
        item_stall   = state_reg != ST_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (kind == KIND_START)
                    begin
                        cmd.take_start = 1'b1;
                    end
                    else
                    begin
                        cmd.take_tick = 1'b1;
                        state_next    = ST_TICK;
                    end
                end
            end
            ST_TICK:
            begin
                cmd.tick_entry = 1'b1;
                retried_next   = 1'b0;
                state_next     = status.throttled ? ST_IDLE : ST_RENDER;
            end
            ST_RENDER:
            begin
                if (!status.running)
                begin
                    state_next = ST_FALLBACK;
                end
                else if (status.elapsed_neg)
                begin
                    cmd.set_dark = 1'b1;
                    state_next   = ST_SCALE;
                end
                else if (status.cycle_zero)
                begin
                    cmd.stop_seq = 1'b1;
                    state_next   = ST_FALLBACK;
                end
                else
                begin
                    cmd.div_op = DIV_CYCLE;
                    state_next = ST_DIV_SEQ;
                end
            end
            ST_DIV_SEQ:
            begin
                if (status.div_done)
                begin
                    if (status.past_end)
                    begin
                        cmd.stop_seq = 1'b1;
                        state_next   = ST_FALLBACK;
                    end
                    else if (status.in_gap)
                    begin
                        cmd.set_dark = 1'b1;
                        state_next   = ST_SCALE;
                    end
                    else
                    begin
                        cmd.seq_params = 1'b1;
                        state_next     = ST_TRI_START;
                    end
                end
            end
            ST_TRI_START:
            begin
                cmd.div_op = DIV_TRI;
                state_next = ST_DIV_TRI;
            end
            ST_DIV_TRI:
            begin
                if (status.div_done)
                begin
                    state_next = ST_GAMMA;
                end
            end
            ST_GAMMA:
            begin
                cmd.gamma_mul = 1'b1;
                state_next    = ST_BR;
            end
            ST_BR:
            begin
                cmd.br_calc = 1'b1;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_mul = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FALLBACK:
            begin
                if (status.pend_nonempty && !retried_reg)
                begin
                    cmd.dequeue  = 1'b1;
                    retried_next = 1'b1;
                    state_next   = ST_RENDER;
                end
                else if (status.mode inside {MODE_SEARCH, MODE_LINKED})
                begin
                    cmd.bg_params = 1'b1;
                    state_next    = ST_BG_START;
                end
                else
                begin
                    cmd.set_off = 1'b1;
                    state_next  = ST_SCALE;
                end
            end
            ST_BG_START:
            begin
                if (status.period_zero)
                begin
                    cmd.br_from_hi = 1'b1;
                    state_next     = ST_SCALE;
                end
                else
                begin
                    cmd.div_op = DIV_PHASE;
                    state_next = ST_DIV_BGP;
                end
            end
            ST_DIV_BGP:
            begin
                if (status.div_done)
                begin
                    state_next = ST_TRI_START;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/led_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// led_pulse_sequencer
// Breathing pulse sequencer for one RGB status LED.
//
// Input channel (item_valid / item_stall): kind 0 is a start request, kind 1
// a frame tick. A request is taken when valid is high and stall is low; stall
// is high while a tick is being worked on. Start requests give no result. A
// tick uses no division when throttled, up to two for a running sequence or
// for background, and up to three when a finished sequence hands over to a
// pending one or to background; every division runs on the single shared
// radix-2 divider.
// Output channel (result_valid / result_stall): one frame per tick that is not
// throttled. The frame sits in an output register; while the receiver stalls,
// the next request is still taken and its frame waits in the final stage.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write only
// while idle. Reset clears the pending queue, the running sequence and the
// frame timer and loads the default register values.
// ----------------------------------------------------------------------------
module led_pulse_sequencer import lps_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int FRAME_MIN_MS  = FRAME_MIN_MS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  logic [31:0] now_ms,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  pulse_count,
    input  logic [15:0] pulse_ms,
    input  logic [15:0] gap_ms,
    input  logic [6:0]  min_pct,
    input  logic [6:0]  max_pct,
    input  logic [15:0] delay_ms,
    input  logic [1:0]  background_mode,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  led_red,
    output logic [7:0]  led_green,
    output logic [7:0]  led_blue,
    output logic        from_sequence,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    lps_cmd_t    cmd;
    lps_status_t status;

    assign cfg_ready = 1'b1;

    lps_controller u_controller
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .kind       (kind),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    lps_datapath
    #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .FRAME_MIN_MS  (FRAME_MIN_MS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .now_ms          (now_ms),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .pulse_count     (pulse_count),
        .pulse_ms        (pulse_ms),
        .gap_ms          (gap_ms),
        .min_pct         (min_pct),
        .max_pct         (max_pct),
        .delay_ms        (delay_ms),
        .background_mode (background_mode),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .led_red         (led_red),
        .led_green       (led_green),
        .led_blue        (led_blue),
        .from_sequence   (from_sequence)
    );

endmodule

>>> tb/sv/led_pulse_sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pulse_sequencer_checker
// Watches the request, frame and register channels of the LED pulse
// sequencer, keeps its own copy of the sequencer state, predicts each frame
// and compares every accepted frame with the oldest prediction.
// ----------------------------------------------------------------------------
module led_pulse_sequencer_checker import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic        kind,
    input  logic [31:0] now_ms,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  pulse_count,
    input  logic [15:0] pulse_ms,
    input  logic [15:0] gap_ms,
    input  logic [6:0]  min_pct,
    input  logic [6:0]  max_pct,
    input  logic [15:0] delay_ms,
    input  logic [1:0]  background_mode,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [7:0]  led_red,
    input  logic [7:0]  led_green,
    input  logic [7:0]  led_blue,
    input  logic        from_sequence,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          errors,
    output int          frames_pending
);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       seq;
    } frame_t;

    typedef struct packed {
        logic [23:0] color;
        logic [31:0] start;
        logic [7:0]  pulses;
        logic [15:0] plen;
        logic [15:0] glen;
        logic [6:0]  lo;
        logic [6:0]  hi;
    } seq_t;

    frame_t      frame_q[$];
    logic [23:0] bg_search_color, bg_linked_color;
    logic [15:0] bg_search_period, bg_linked_period;
    logic [6:0]  bg_floor, bg_search_peak, bg_linked_peak;
    logic        running, ticked;
    seq_t        cur;
    logic [31:0] last_frame;
    seq_t        queue_fifo[$];

    localparam logic [7:0] GAMMA [256] = '{
        0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,1,1,1,1,
        1,1,1,1,1,1,1,1,1,2,2,2,2,2,2,2,2,3,3,3,3,3,3,3,4,4,4,4,4,5,5,5,
        5,6,6,6,6,7,7,7,7,8,8,8,9,9,9,10,10,10,11,11,11,12,12,13,13,13,14,14,15,15,16,16,
        17,17,18,18,19,19,20,20,21,21,22,22,23,24,24,25,25,26,27,27,28,29,29,30,
        31,32,32,33,34,35,35,36,37,38,39,39,40,41,42,43,44,45,46,47,48,49,50,50,
        51,52,54,55,56,57,58,59,60,61,62,63,64,66,67,68,69,70,72,73,74,75,77,78,
        79,81,82,83,85,86,87,89,90,92,93,95,96,98,99,101,102,104,105,107,109,110,112,114,
        115,117,119,120,122,124,126,127,129,131,133,135,137,138,140,142,
        144,146,148,150,152,154,156,158,160,162,164,167,169,171,173,175,
        177,180,182,184,186,189,191,193,196,198,200,203,205,208,210,213,
        215,218,220,223,225,228,231,233,236,239,241,244,247,249,252,255
    };

    function automatic int unsigned level_of(logic [6:0] pct);
        int unsigned v;
        v = int'(pct) * 255 / 100;
        return (v > 255) ? 255 : v;
    endfunction

    function automatic int unsigned breath(int unsigned ph, int unsigned per,
                                           int unsigned lo, int unsigned hi);
        int unsigned tri_pos, span;
        if (per == 0)
        begin
            return hi;
        end
        tri_pos = (ph % per) * 510 / per;
        if (tri_pos > 255)
        begin
            tri_pos = 510 - tri_pos;
        end
        span = (hi > lo) ? hi - lo : 0;
        return lo + GAMMA[tri_pos[7:0]] * span / 255;
    endfunction

    function automatic frame_t shade(logic [23:0] rgb, int unsigned br, logic seq);
        frame_t f;
        f.r   = 8'((rgb[23:16] * br + 127) / 255);
        f.g   = 8'((rgb[15:8] * br + 127) / 255);
        f.b   = 8'((rgb[7:0] * br + 127) / 255);
        f.seq = seq;
        return f;
    endfunction

    function automatic void load_seq(seq_t s);
        cur     = s;
        running = (s.pulses != 0) && (s.plen != 0);
    endfunction

    function automatic void dequeue_seq(logic [31:0] now);
        seq_t s;
        if (queue_fifo.size() == 0)
        begin
            return;
        end
        s = queue_fifo.pop_front();
        if (now > s.start)
        begin
            s.start = now;
        end
        load_seq(s);
    endfunction

    function automatic bit seq_frame(logic [31:0] now, output frame_t f);
        logic [31:0] el, cyc;
        if (!running)
        begin
            return 0;
        end
        el = now - cur.start;
        f  = shade(24'd0, 0, 1'b1);
        if (el[31])
        begin
            return 1;
        end
        cyc = 32'(cur.plen) + 32'(cur.glen);
        if (cyc == 0 || el / cyc >= cur.pulses)
        begin
            running = 0;
            return 0;
        end
        if (el % cyc >= cur.plen)
        begin
            return 1;
        end
        f = shade(cur.color, breath(el % cyc, cur.plen, level_of(cur.lo), level_of(cur.hi)),
                  1'b1);
        return 1;
    endfunction

    function automatic void take_request();
        seq_t   s;
        frame_t f;
        s.color  = {red, green, blue};
        s.start  = now_ms + 32'(delay_ms);
        s.pulses = pulse_count;
        s.plen   = pulse_ms;
        s.glen   = gap_ms;
        s.lo     = min_pct;
        s.hi     = max_pct;
        if (kind == KIND_START)
        begin
            if (ticked)
            begin
                load_seq(s);
            end
            else if (pulse_count != 0 && pulse_ms != 0)
            begin
                if (queue_fifo.size() >= PENDING_DEPTH_DEF)
                begin
                    void'(queue_fifo.pop_front());
                end
                queue_fifo.push_back(s);
            end
            return;
        end
        if (!ticked)
        begin
            ticked = 1;
            if (!running)
            begin
                dequeue_seq(now_ms);
            end
        end
        if (last_frame != 0 && (now_ms - last_frame) < FRAME_MIN_MS_DEF)
        begin
            return;
        end
        last_frame = now_ms;
        if (seq_frame(now_ms, f))
        begin
            frame_q.push_back(f);
            return;
        end
        if (!running && queue_fifo.size() > 0)
        begin
            dequeue_seq(now_ms);
            if (seq_frame(now_ms, f))
            begin
                frame_q.push_back(f);
                return;
            end
        end
        if (background_mode == MODE_SEARCH)
        begin
            f = shade(bg_search_color, breath(now_ms, bg_search_period, level_of(bg_floor),
                      level_of(bg_search_peak)), 1'b0);
        end
        else if (background_mode == MODE_LINKED)
        begin
            f = shade(bg_linked_color, breath(now_ms, bg_linked_period, level_of(bg_floor),
                      level_of(bg_linked_peak)), 1'b0);
        end
        else
        begin
            f = shade(24'd0, 0, 1'b0);
        end
        frame_q.push_back(f);
    endfunction

    assign frames_pending = frame_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        frame_t e;
        if (!rst_n)
        begin
            errors           = 0;
            frame_q.delete();
            queue_fifo.delete();
            bg_search_color  = 24'hFF;
            bg_linked_color  = 24'hFF;
            bg_search_period = 16'd1600;
            bg_linked_period = 16'd500;
            bg_floor         = 7'd1;
            bg_search_peak   = 7'd65;
            bg_linked_peak   = 7'd80;
            running          = 0;
            ticked           = 0;
            cur              = '0;
            last_frame       = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SEARCH_COLOR:  bg_search_color  = cfg_data;
                    REG_LINKED_COLOR:  bg_linked_color  = cfg_data;
                    REG_SEARCH_PERIOD: bg_search_period = cfg_data[15:0];
                    REG_LINKED_PERIOD: bg_linked_period = cfg_data[15:0];
                    REG_BG_FLOOR:      bg_floor         = cfg_data[6:0];
                    REG_SEARCH_PEAK:   bg_search_peak   = cfg_data[6:0];
                    REG_LINKED_PEAK:   bg_linked_peak   = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (frame_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected frame: actual %h %h %h seq %b", $time,
                             led_red, led_green, led_blue, from_sequence);
                end
                else
                begin
                    e = frame_q.pop_front();
                    if (e != {led_red, led_green, led_blue, from_sequence})
                    begin
                        errors++;
                        $display("%0t frame mismatch: expected %h %h %h seq %b, actual %h %h %h seq %b",
                                 $time, e.r, e.g, e.b, e.seq,
                                 led_red, led_green, led_blue, from_sequence);
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                take_request();
            end
        end
    end

endmodule

>>> tb/sv/led_pulse_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pulse_sequencer_tb
// Drives start requests, frame ticks and register writes into the LED pulse
// sequencer under several idle and stall patterns; the checker predicts and
// compares every frame.
// ----------------------------------------------------------------------------
module led_pulse_sequencer_tb import lps_pkg::*;;

    logic        clk, rst_n;
    logic        item_valid, item_stall, kind;
    logic [31:0] now_ms;
    logic [7:0]  red, green, blue, pulse_count;
    logic [15:0] pulse_ms, gap_ms, delay_ms;
    logic [6:0]  min_pct, max_pct;
    logic [1:0]  background_mode;
    logic        result_valid, result_stall;
    logic [7:0]  led_red, led_green, led_blue;
    logic        from_sequence;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    int          errors, frames_pending;
    int          send_idle_pct, recv_stall_pct, hold_cycles;
    logic        hold_req, hold_done;
    logic [31:0] clock_ms;

    led_pulse_sequencer dut (.*);
    led_pulse_sequencer_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_cycles  <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_cycles  <= 3000;
            hold_done    <= 1'b1;
            result_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles  <= hold_cycles - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send(logic k, logic [31:0] t, logic [7:0] r, logic [7:0] g,
                        logic [7:0] b, logic [7:0] cnt, logic [15:0] pl,
                        logic [15:0] gl, logic [6:0] lo, logic [6:0] hi,
                        logic [15:0] dl, logic [1:0] mode);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid      <= 1'b1;
        kind            <= k;
        now_ms          <= t;
        red             <= r;
        green           <= g;
        blue            <= b;
        pulse_count     <= cnt;
        pulse_ms        <= pl;
        gap_ms          <= gl;
        min_pct         <= lo;
        max_pct         <= hi;
        delay_ms        <= dl;
        background_mode <= mode;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic tick(logic [31:0] t, logic [1:0] mode);
        send(1'b1, t, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             16'($urandom), 16'($urandom), 7'($urandom), 7'($urandom),
             16'($urandom), mode);
    endtask

    task automatic start_seq(logic [31:0] t);
        logic [7:0]  cnt;
        logic [15:0] pl;
        cnt = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
        pl  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
        if ($urandom_range(15) == 0)
        begin
            pl = 16'd0;
        end
        send(KIND_START, t, 8'($urandom), 8'($urandom), 8'($urandom), cnt, pl,
             ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200)),
             7'($urandom_range(127)), 7'($urandom_range(127)),
             ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100)),
             2'($urandom));
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (frames_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_all(int pick);
        logic [6:0] f, sp, lp;
        f  = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : 7'($urandom_range(100));
        sp = (pick == 0) ? 7'd127 : (pick == 1) ? 7'd0 : 7'($urandom_range(100));
        lp = (pick == 0) ? 7'd100 : 7'($urandom_range(127));
        write_reg(REG_SEARCH_COLOR, (pick == 0) ? 24'hFFFFFF : 24'($urandom));
        write_reg(REG_LINKED_COLOR, (pick == 1) ? 24'h000000 : 24'($urandom));
        write_reg(REG_SEARCH_PERIOD, (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFF
                                                  : 24'($urandom_range(1, 3000)));
        write_reg(REG_LINKED_PERIOD, (pick == 0) ? 24'hFFFF : (pick == 1) ? 24'd0
                                                  : 24'($urandom_range(1, 3000)));
        write_reg(REG_BG_FLOOR, 24'(f));
        write_reg(REG_SEARCH_PEAK, 24'(sp));
        write_reg(REG_LINKED_PEAK, 24'(lp));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 0;
        item_valid = 0; kind = 0; now_ms = 0; red = 0; green = 0; blue = 0;
        pulse_count = 0; pulse_ms = 0; gap_ms = 0; min_pct = 0; max_pct = 0;
        delay_ms = 0; background_mode = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        send_idle_pct = 0; recv_stall_pct = 0; clock_ms = 0; hold_req = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queued starts before first tick: overflow, empty, extremes
        send(KIND_START, 32'd0, 8'hFF, 8'h00, 8'h80, 8'd0, 16'd100, 16'd0, 7'd0,
             7'd100, 16'd0, 2'd0);
        send(KIND_START, 32'd0, 8'hFF, 8'hFF, 8'hFF, 8'd2, 16'd0, 16'd0, 7'd0,
             7'd100, 16'd0, 2'd0);
        send(KIND_START, 32'd0, 8'h00, 8'h00, 8'h00, 8'd1, 16'd50, 16'd10, 7'd0,
             7'd100, 16'd0, 2'd3);
        send(KIND_START, 32'hFFFF_FFF0, 8'h12, 8'h34, 8'h56, 8'd255, 16'hFFFF,
             16'hFFFF, 7'd127, 7'd127, 16'hFFFF, 2'd0);
        send(KIND_START, 32'd5, 8'hFF, 8'h7F, 8'h01, 8'd3, 16'd40, 16'd20, 7'd80,
             7'd20, 16'd30, 2'd0);
        send(KIND_START, 32'd5, 8'hAA, 8'h55, 8'hFF, 8'd2, 16'd1, 16'd0, 7'd0,
             7'd100, 16'd0, 2'd0);
        send(KIND_START, 32'd5, 8'hFF, 8'hFF, 8'hFF, 8'd2, 16'd60, 16'd12, 7'd0,
             7'd100, 16'd0, 2'd0);
        tick(32'd0, 2'd1);
        tick(32'd5, 2'd2);
        tick(32'd12, 2'd1);
        tick(32'd30, 2'd0);
        tick(32'd60, 2'd3);
        tick(32'd100, 2'd2);
        tick(32'd200, 2'd1);
        tick(32'd500, 2'd2);
        send(KIND_START, 32'd510, 8'hFF, 8'h00, 8'hFF, 8'd1, 16'd0, 16'd5, 7'd0,
             7'd100, 16'd0, 2'd0);
        tick(32'd520, 2'd1);
        send(KIND_START, 32'hFFFF_FFE0, 8'h01, 8'hFE, 8'h80, 8'd2, 16'd20, 16'd0,
             7'd100, 7'd0, 16'd10, 2'd0);
        tick(32'hFFFF_FFE8, 2'd1);
        tick(32'hFFFF_FFF8, 2'd2);
        tick(32'd4, 2'd1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_all(ph < 2 ? ph : 2);
            send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 51 : 37) : 0;
            recv_stall_pct = (ph % 4 == 2) ? 51 : (ph % 4 == 3) ? 37 : 0;
            if (ph == 4)
            begin
                hold_req = 1'b1;
            end
            clock_ms = $urandom;
            for (int i = 0; i < 150; i++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    start_seq(clock_ms + $urandom_range(50));
                end
                else
                begin
                    clock_ms = clock_ms + (($urandom_range(9) == 0) ? $urandom_range(11)
                                                                  : $urandom_range(12, 120));
                    tick(clock_ms, ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2)));
                end
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
